// ----- sv/tlpb_pkg.sv -----
`timescale 1ns / 1ps
package tlpb_pkg;
	typedef struct packed {
		logic        operation;
		logic        side;
		logic [9:0]  order_slot;
		logic [31:0] price;
		logic [23:0] quantity;
	} tlpb_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] executed_volume;
		logic [23:0] remaining_volume;
		logic [31:0] best_price;
		logic [31:0] evicted_price;
	} tlpb_out_t;

	localparam logic [2:0] ST_MERGED   = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_EVICTED  = 3'd2;
	localparam logic [2:0] ST_DEEP     = 3'd3;
	localparam logic [2:0] ST_EXECUTED = 3'd4;
	localparam logic [2:0] ST_UNKNOWN  = 3'd5;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_EXEC = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SLOT,
		S_SCAN,
		S_SCAN_W,
		S_SHIFT,
		S_SHIFT_W,
		S_SWEEP,
		S_SWEEP_W,
		S_ASK,
		S_ASK_W,
		S_DONE
	} tlpb_state_t;
endpackage

// ----- sv/top_levels_price_book_core.sv -----
`timescale 1ns / 1ps
// Price level book, best LEVELS levels per side, order slot table for asks.
// Add scans to its position, then shifts the lower levels; execute sweeps bid levels
// while compacting them, then scans ask levels. One item at a time; each level visit
// reads the entry, then compares and writes it back. Reset clears counts, then a
// clearing pass wipes all ORDER_SLOTS slot entries with busy high. Results are strobed
// for one cycle with done; the receiver cannot stall.
module top_levels_price_book_core #(
	parameter int LEVELS      = 128,
	parameter int ORDER_SLOTS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tlpb_pkg::tlpb_in_t   item_in,
	output logic                 done,
	output tlpb_pkg::tlpb_out_t  result
);
	import tlpb_pkg::*;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW = $clog2(LEVELS + 1);
	localparam int SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
	localparam int DW = SW + 1;

	// Level memory: bids in the lower half, asks in the upper half, {price, volume}.
	logic          mem_we;
	logic          mem_side;
	logic [LW-1:0] mem_waddr, mem_raddr;
	logic [63:0]   mem_wdata, lv_rd;

	tlpb_level_mem #(.DEPTH(1 << (LW + 1)), .AW(LW + 1)) u_level (
		.clk(clk), .we(mem_we), .waddr({mem_side, mem_waddr}), .wdata(mem_wdata),
		.raddr({mem_side, mem_raddr}), .rdata(lv_rd));

	// Slot table: {valid, price, volume}, wiped by the clearing pass after reset.
	logic          slot_we;
	logic [SW-1:0] slot_addr;
	logic [56:0]   slot_wdata, slot_rd;
	logic [SW-1:0] clr_q, clr_d;

	tlpb_slot_mem #(.DEPTH(ORDER_SLOTS), .AW(SW)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_addr), .wdata(slot_wdata),
		.raddr(slot_addr), .rdata(slot_rd));

	tlpb_state_t   state_q, state_d;
	tlpb_in_t      item_q;
	logic [CW-1:0] ask_cnt_q, bid_cnt_q;
	logic [CW-1:0] idx_q, idx_d;      // scan position
	logic [CW-1:0] end_q, end_d;      // shift bound / cleared count
	logic [63:0]   carry_q, carry_d;  // entry carried during insert shift
	logic [31:0]   xprice_q, xprice_d;
	logic [23:0]   rem_q, rem_d, xvol_q, xvol_d;
	tlpb_out_t     res_q, res_d;
	logic          done_q, done_d;
	logic          slot_hit_q, slot_hit_d;
	logic [CW-1:0] ask_cnt_d, bid_cnt_d;

	logic          is_ask;
	logic [CW-1:0] cnt_cur;
	logic [31:0]   rp, rv;
	logic          better;
	logic [32:0]   vsum;
	logic [23:0]   take;
	logic [31:0]   rv_new;

	assign is_ask  = (item_q.operation == OP_ADD) && item_q.side;
	assign cnt_cur = is_ask ? ask_cnt_q : bid_cnt_q;
	assign rp      = lv_rd[63:32];
	assign rv      = lv_rd[31:0];
	assign better  = is_ask ? (rp < item_q.price) : (rp > item_q.price);
	assign vsum    = {1'b0, rv} + {9'd0, item_q.quantity};
	assign take    = ({8'd0, rem_q} < rv) ? rem_q : rv[23:0];
	assign rv_new  = rv - {8'd0, take};

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ask_cnt_q <= '0;
			bid_cnt_q <= '0;
			done_q    <= 1'b0;
			clr_q     <= '0;
		end else begin
			state_q   <= state_d;
			ask_cnt_q <= ask_cnt_d;
			bid_cnt_q <= bid_cnt_d;
			done_q    <= done_d;
			clr_q     <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item_in;
		end
		idx_q      <= idx_d;
		end_q      <= end_d;
		carry_q    <= carry_d;
		xprice_q   <= xprice_d;
		xvol_q     <= xvol_d;
		rem_q      <= rem_d;
		res_q      <= res_d;
		slot_hit_q <= slot_hit_d;
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		end_d      = end_q;
		carry_d    = carry_q;
		xprice_d   = xprice_q;
		xvol_d     = xvol_q;
		rem_d      = rem_q;
		res_d      = res_q;
		done_d     = 1'b0;
		slot_hit_d = slot_hit_q;
		ask_cnt_d  = ask_cnt_q;
		bid_cnt_d  = bid_cnt_q;
		clr_d      = clr_q;
		mem_we     = 1'b0;
		mem_side   = is_ask;
		mem_waddr  = idx_q[LW-1:0];
		mem_raddr  = idx_q[LW-1:0];
		mem_wdata  = lv_rd;
		slot_we    = 1'b0;
		slot_addr  = SW'(item_q.order_slot);
		slot_wdata = {1'b0, item_q.price, item_q.quantity};
		case (state_q)
			// wipe one slot entry per cycle after reset
			S_CLEAR: begin
				slot_we    = 1'b1;
				slot_addr  = clr_q;
				slot_wdata = '0;
				clr_d      = clr_q + 1'b1;
				if (clr_q == SW'(ORDER_SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				slot_addr = SW'(item_in.order_slot);
				if (start) begin
					idx_d = '0;
					res_d = '0;
					slot_hit_d = ({22'd0, item_in.order_slot} < 32'(ORDER_SLOTS));
					state_d = (item_in.operation == OP_ADD) ? S_SCAN : S_SLOT;
					mem_raddr = '0;
					mem_side = 1'b0;
				end
			end
			// read first slot word and first bid entry (for best price)
			S_SLOT: begin
				if (!slot_hit_q || !slot_rd[56]) begin
					res_d.status = ST_UNKNOWN;
					res_d.best_price = (bid_cnt_q != '0) ? lv_rd[63:32] : 32'd0;
					state_d = S_DONE;
				end else begin
					xprice_d = slot_rd[55:24];
					xvol_d   = slot_rd[23:0];
					rem_d    = slot_rd[23:0];
					end_d    = '0;
					idx_d    = '0;
					state_d  = S_SWEEP;
				end
			end
			// add: issue read at idx
			S_SCAN: begin
				mem_raddr = idx_q[LW-1:0];
				if (idx_q >= cnt_cur) begin
					// append position reached without hitting a level
					if (idx_q >= CW'(LEVELS)) begin
						res_d.status = ST_DEEP;
						idx_d = '0;
						state_d = S_DONE;
					end else begin
						res_d.status = ST_INSERTED;
						end_d   = cnt_cur;
						carry_d = {item_q.price, 8'd0, item_q.quantity};
						state_d = S_SHIFT;
					end
				end else begin
					state_d = S_SCAN_W;
				end
			end
			S_SCAN_W: begin
				if (better) begin
					idx_d = idx_q + 1'b1;
					state_d = S_SCAN;
				end else if (rp == item_q.price) begin
					mem_we = 1'b1;
					mem_wdata = {rp, vsum[32] ? 32'hFFFF_FFFF : vsum[31:0]};
					res_d.status = ST_MERGED;
					idx_d = '0;
					state_d = S_DONE;
				end else begin
					if (cnt_cur >= CW'(LEVELS)) begin
						res_d.status = ST_EVICTED;
						end_d = CW'(LEVELS - 1);
					end else begin
						res_d.status = ST_INSERTED;
						end_d = cnt_cur;
					end
					carry_d = {item_q.price, 8'd0, item_q.quantity};
					state_d = S_SHIFT;
				end
			end
			// insert: read old entry at idx, write carry, carry old forward
			S_SHIFT: begin
				mem_raddr = idx_q[LW-1:0];
				state_d = S_SHIFT_W;
			end
			S_SHIFT_W: begin
				if (idx_q == CW'(LEVELS - 1) && res_q.status == ST_EVICTED) begin
					res_d.evicted_price = rp;
				end
				mem_we = 1'b1;
				mem_wdata = carry_q;
				carry_d = lv_rd;
				if (idx_q >= end_q) begin
					if (is_ask) ask_cnt_d = end_q + 1'b1;
					else bid_cnt_d = end_q + 1'b1;
					idx_d = '0;
					state_d = S_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_SHIFT;
				end
			end
			// execute: sweep bids; end_q counts cleared levels, writes compact
			S_SWEEP: begin
				mem_side = 1'b0;
				mem_raddr = idx_q[LW-1:0];
				if (idx_q >= bid_cnt_q) begin
					bid_cnt_d = bid_cnt_q - end_q;
					idx_d = '0;
					state_d = S_ASK;
				end else begin
					state_d = S_SWEEP_W;
				end
			end
			S_SWEEP_W: begin
				mem_side = 1'b0;
				mem_waddr = LW'(idx_q - end_q);
				if (rp >= xprice_q && res_q.executed_volume != 24'd1) begin
					// sweeping level
					rem_d = rem_q - take;
					if (rv_new == 32'd0) begin
						end_d = end_q + 1'b1;
					end else begin
						mem_we = 1'b1;
						mem_wdata = {rp, rv_new};
					end
					if (rem_q - take == 24'd0) res_d.executed_volume = 24'd1;
				end else begin
					// beyond sweep: compact only
					res_d.executed_volume = 24'd1;
					mem_we = (end_q != '0);
				end
				if (end_q == '0 && !(rp >= xprice_q && res_q.executed_volume != 24'd1)
						&& res_q.executed_volume == 24'd1) begin
					bid_cnt_d = bid_cnt_q;
					idx_d = '0;
					state_d = S_ASK;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_SWEEP;
				end
			end
			S_ASK: begin
				mem_side = 1'b1;
				mem_raddr = idx_q[LW-1:0];
				if (idx_q == '0) begin
					res_d.executed_volume = xvol_q - rem_q;
					res_d.remaining_volume = rem_q;
				end
				if (idx_q >= ask_cnt_q) begin
					idx_d = '0;
					state_d = S_DONE;
				end else begin
					state_d = S_ASK_W;
				end
			end
			S_ASK_W: begin
				mem_side = 1'b1;
				if (rp == xprice_q) begin
					mem_we = 1'b1;
					mem_wdata = {rp, (rv > {8'd0, res_q.executed_volume}) ?
						rv - {8'd0, res_q.executed_volume} : 32'd0};
					idx_d = '0;
					state_d = S_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_ASK;
				end
			end
			// read entry 0 of the affected side for best price, record ask adds in the slot table, then report
			S_DONE: begin
				mem_side = (item_q.operation == OP_ADD) ? item_q.side : 1'b0;
				mem_raddr = '0;
				idx_d = '0;
				if (idx_q == '0 && res_q.status != ST_UNKNOWN) begin
					idx_d = CW'(1);
					if (item_q.operation == OP_ADD && item_q.side && slot_hit_q) begin
						slot_we = 1'b1;
						slot_wdata = {res_q.status != ST_DEEP, item_q.price, item_q.quantity};
					end
					if (item_q.operation == OP_EXEC) res_d.status = ST_EXECUTED;
				end else begin
					if (res_q.status != ST_UNKNOWN) begin
						res_d.best_price = (cnt_cur != '0) ? lv_rd[63:32] : 32'd0;
					end
					done_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- sv/tlpb_level_mem.sv -----
`timescale 1ns / 1ps
module tlpb_level_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/tlpb_slot_mem.sv -----
`timescale 1ns / 1ps
module tlpb_slot_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [56:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [56:0]   rdata
);
	logic [56:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import tlpb_pkg::*;

	localparam int LEVELS      = 128;
	localparam int ORDER_SLOTS = 1024;

	// Directed row: the item, whether an expected result is typed in, and that result.
	typedef struct {
		tlpb_in_t  stim;
		bit        typed;
		tlpb_out_t want;
	} book_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	tlpb_in_t  item_in;
	logic      done;
	tlpb_out_t result;

	// Shadow copy of the book, kept in step with every accepted item.
	logic [31:0] ask_px  [LEVELS];
	logic [31:0] ask_vol [LEVELS];
	logic [31:0] bid_px  [LEVELS];
	logic [31:0] bid_vol [LEVELS];
	int          ask_n;
	int          bid_n;
	logic [31:0] slot_px  [ORDER_SLOTS];
	logic [23:0] slot_qty [ORDER_SLOTS];
	bit          slot_live[ORDER_SLOTS];

	tlpb_out_t   pending_results[$];
	int          mismatches;
	int          results_seen;
	book_row_t   rows[$];

	top_levels_price_book_core #(.LEVELS(LEVELS), .ORDER_SLOTS(ORDER_SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item_in(item_in), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Generous time cap, since long shift/sweep chains make items slow.
	initial begin
		#200ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("MISMATCH %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	// Merge, insert or drop as deep on one side; return the status, evicted price and new best.
	function automatic void book_add(input bit is_ask, input logic [31:0] p,
			input logic [23:0] q, inout tlpb_out_t r);
		int n;
		int pos;
		logic [32:0] sum;
		n   = is_ask ? ask_n : bid_n;
		pos = 0;
		while (pos < n && (is_ask ? (ask_px[pos] < p) : (bid_px[pos] > p)))
			pos++;
		if (pos < n && (is_ask ? ask_px[pos] : bid_px[pos]) == p) begin
			sum = (is_ask ? ask_vol[pos] : bid_vol[pos]) + q;
			if (sum[32])
				sum[31:0] = 32'hFFFF_FFFF;
			if (is_ask)
				ask_vol[pos] = sum[31:0];
			else
				bid_vol[pos] = sum[31:0];
			r.status = ST_MERGED;
		end else if (pos >= LEVELS) begin
			r.status = ST_DEEP;
		end else begin
			if (n >= LEVELS) begin
				r.status        = ST_EVICTED;
				r.evicted_price = is_ask ? ask_px[LEVELS-1] : bid_px[LEVELS-1];
				n = LEVELS - 1;
			end else begin
				r.status = ST_INSERTED;
			end
			for (int k = n; k > pos; k--) begin
				if (is_ask) begin
					ask_px[k] = ask_px[k-1];
					ask_vol[k] = ask_vol[k-1];
				end else begin
					bid_px[k] = bid_px[k-1];
					bid_vol[k] = bid_vol[k-1];
				end
			end
			if (is_ask) begin
				ask_px[pos] = p;
				ask_vol[pos] = q;
				ask_n = n + 1;
			end else begin
				bid_px[pos] = p;
				bid_vol[pos] = q;
				bid_n = n + 1;
			end
		end
		if (is_ask)
			r.best_price = (ask_n > 0) ? ask_px[0] : '0;
		else
			r.best_price = (bid_n > 0) ? bid_px[0] : '0;
	endfunction

	// Sweep bids against a recorded ask order, then trim its ask level.
	function automatic void book_execute(input logic [9:0] slot, inout tlpb_out_t r);
		logic [31:0] p;
		logic [31:0] left;
		logic [31:0] take;
		logic [31:0] filled;
		int cleared;
		cleared = 0;
		r.best_price = (bid_n > 0) ? bid_px[0] : '0;
		if (slot >= ORDER_SLOTS || !slot_live[slot]) begin
			r.status = ST_UNKNOWN;
			return;
		end
		p    = slot_px[slot];
		left = {8'd0, slot_qty[slot]};
		for (int i = 0; i < bid_n && bid_px[i] >= p; i++) begin
			take = (left < bid_vol[i]) ? left : bid_vol[i];
			bid_vol[i] -= take;
			left -= take;
			if (bid_vol[i] == 0)
				cleared++;
			if (left == 0)
				break;
		end
		if (cleared > 0) begin
			for (int i = cleared; i < bid_n; i++) begin
				bid_px[i-cleared] = bid_px[i];
				bid_vol[i-cleared] = bid_vol[i];
			end
			bid_n -= cleared;
		end
		filled = {8'd0, slot_qty[slot]} - left;
		for (int i = 0; i < ask_n; i++) begin
			if (ask_px[i] == p) begin
				ask_vol[i] = (ask_vol[i] > filled) ? ask_vol[i] - filled : '0;
				break;
			end
		end
		r.status           = ST_EXECUTED;
		r.executed_volume  = filled[23:0];
		r.remaining_volume = left[23:0];
		r.best_price       = (bid_n > 0) ? bid_px[0] : '0;
	endfunction

	function automatic tlpb_out_t predict_book(input tlpb_in_t it);
		tlpb_out_t r;
		r = '0;
		if (it.operation == OP_ADD) begin
			book_add(it.side, it.price, it.quantity, r);
			if (it.side && it.order_slot < ORDER_SLOTS) begin
				if (r.status == ST_DEEP) begin
					slot_live[it.order_slot] = 1'b0;
				end else begin
					slot_px[it.order_slot]   = it.price;
					slot_qty[it.order_slot]  = it.quantity;
					slot_live[it.order_slot] = 1'b1;
				end
			end
		end else begin
			book_execute(it.order_slot, r);
		end
		return r;
	endfunction

	// Sample results at the edge that ends the strobe cycle.
	always @(posedge clk) begin
		tlpb_out_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {29'd0, result.status}, '0);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", {29'd0, result.status}, {29'd0, want.status});
				if (result.executed_volume !== want.executed_volume)
					report_mismatch("executed_volume", {8'd0, result.executed_volume},
						{8'd0, want.executed_volume});
				if (result.remaining_volume !== want.remaining_volume)
					report_mismatch("remaining_volume", {8'd0, result.remaining_volume},
						{8'd0, want.remaining_volume});
				if (result.best_price !== want.best_price)
					report_mismatch("best_price", result.best_price, want.best_price);
				if (result.evicted_price !== want.evicted_price)
					report_mismatch("evicted_price", result.evicted_price, want.evicted_price);
			end
		end
	end

	// Drive one item and hold start until busy drops; drop start over idle gaps.
	task automatic send_item(input tlpb_in_t it, input bit typed, input tlpb_out_t want);
		tlpb_out_t model;
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		item_in <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// Block is idle again at this edge: predict now so the queue leads the result.
		model = predict_book(it);
		if (typed && model !== want)
			report_mismatch("typed row disagrees with book", {29'd0, want.status},
				{29'd0, model.status});
		pending_results.push_back(model);
	endtask

	function automatic tlpb_out_t typed_out(input logic [2:0] st, input logic [23:0] ex,
			input logic [23:0] rem, input logic [31:0] best, input logic [31:0] ev);
		tlpb_out_t r;
		r.status = st;
		r.executed_volume = ex;
		r.remaining_volume = rem;
		r.best_price = best;
		r.evicted_price = ev;
		return r;
	endfunction

	function automatic tlpb_in_t make_item(input logic op, input logic sd,
			input logic [9:0] slot, input logic [31:0] p, input logic [23:0] q);
		tlpb_in_t it;
		it.operation = op;
		it.side = sd;
		it.order_slot = slot;
		it.price = p;
		it.quantity = q;
		return it;
	endfunction

	task automatic add_row(input tlpb_in_t it, input bit typed, input tlpb_out_t want);
		book_row_t r;
		r.stim = it;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	// Random book activity clustered near a moving mid price so levels cross.
	task automatic random_item(input logic [31:0] mid, input int spread);
		tlpb_in_t it;
		int roll;
		roll = $urandom_range(0, 99);
		it = make_item(OP_ADD, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 63)),
			mid - spread + $urandom_range(0, 2 * spread), 24'($urandom_range(0, 5000)));
		if (roll < 30) begin
			it.operation = OP_EXEC;
		end else if (roll < 36) begin
			it.price = $urandom;
			it.quantity = 24'($urandom);
			it.order_slot = 10'($urandom);
		end else if (roll < 40) begin
			it.quantity = 24'hFFFFFF - 24'($urandom_range(0, 3));
		end else if (roll < 42) begin
			it.quantity = '0;
		end
		send_item(it, 1'b0, '0);
	endtask

	initial begin
		tlpb_out_t none;
		none = '0;
		mismatches = 0;
		results_seen = 0;
		ask_n = 0;
		bid_n = 0;
		for (int i = 0; i < ORDER_SLOTS; i++)
			slot_live[i] = 1'b0;
		start   = 1'b0;
		item_in = '0;
		arst_n  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty book, extremes, merges of full-scale quantities, zero quantity, unknown orders.
		add_row(make_item(OP_EXEC, 1'b0, 10'd5, '0, '0), 1'b1,
			typed_out(ST_UNKNOWN, '0, '0, '0, '0));
		add_row(make_item(OP_ADD, 1'b0, 10'd0, 32'd100, 24'd50), 1'b1,
			typed_out(ST_INSERTED, '0, '0, 32'd100, '0));
		add_row(make_item(OP_ADD, 1'b0, 10'd0, 32'd100, 24'hFFFFFF), 1'b1,
			typed_out(ST_MERGED, '0, '0, 32'd100, '0));
		add_row(make_item(OP_ADD, 1'b0, 10'h3FF, 32'hFFFF_FFFF, 24'd10), 1'b1,
			typed_out(ST_INSERTED, '0, '0, 32'hFFFF_FFFF, '0));
		add_row(make_item(OP_ADD, 1'b0, 10'd1, 32'd0, 24'd0), 1'b1,
			typed_out(ST_INSERTED, '0, '0, 32'hFFFF_FFFF, '0));
		add_row(make_item(OP_ADD, 1'b1, 10'd1, 32'd90, 24'd30), 1'b1,
			typed_out(ST_INSERTED, '0, '0, 32'd90, '0));
		add_row(make_item(OP_ADD, 1'b1, 10'h3FF, 32'hFFFF_FFFF, 24'hFFFFFF), 1'b1,
			typed_out(ST_INSERTED, '0, '0, 32'd90, '0));
		add_row(make_item(OP_ADD, 1'b1, 10'd2, 32'd0, 24'd0), 1'b1,
			typed_out(ST_INSERTED, '0, '0, 32'd0, '0));
		add_row(make_item(OP_ADD, 1'b1, 10'd3, 32'd90, 24'd7), 1'b0, none);
		add_row(make_item(OP_EXEC, 1'b0, 10'd1, '0, '0), 1'b0, none);
		add_row(make_item(OP_EXEC, 1'b0, 10'd1, '0, '0), 1'b0, none);
		add_row(make_item(OP_EXEC, 1'b1, 10'h3FF, '1, '1), 1'b0, none);
		add_row(make_item(OP_EXEC, 1'b0, 10'd2, '0, '0), 1'b0, none);
		add_row(make_item(OP_ADD, 1'b0, 10'd0, 32'd100, 24'hFFFFFF), 1'b0, none);
		add_row(make_item(OP_EXEC, 1'b0, 10'd3, '0, '0), 1'b0, none);
		foreach (rows[i])
			send_item(rows[i].stim, rows[i].typed, rows[i].want);

		// Fill the ask side past LEVELS to reach eviction and deep drops.
		for (int i = 0; i < LEVELS + 6; i++)
			send_item(make_item(OP_ADD, 1'b1, 10'(100 + i), 32'(1000 + 2 * i),
				24'($urandom_range(1, 900))), 1'b0, none);
		send_item(make_item(OP_ADD, 1'b1, 10'd400, 32'd999_999, 24'd5), 1'b0, none);
		send_item(make_item(OP_EXEC, 1'b0, 10'd400, '0, '0), 1'b0, none);
		send_item(make_item(OP_ADD, 1'b1, 10'd401, 32'd1001, 24'd5), 1'b0, none);
		// Fill bids likewise, then sweep several levels at once.
		for (int i = 0; i < LEVELS + 4; i++)
			send_item(make_item(OP_ADD, 1'b0, 10'($urandom), 32'(900 + 2 * i),
				24'($urandom_range(1, 60))), 1'b0, none);
		send_item(make_item(OP_ADD, 1'b0, 10'd0, 32'd1, 24'd3), 1'b0, none);
		send_item(make_item(OP_ADD, 1'b1, 10'd402, 32'd1100, 24'd2000), 1'b0, none);
		send_item(make_item(OP_EXEC, 1'b0, 10'd402, '0, '0), 1'b0, none);
		send_item(make_item(OP_EXEC, 1'b0, 10'd101, '0, '0), 1'b0, none);

		// Random part, around a few mid prices including the extremes.
		for (int i = 0; i < 120; i++) begin
			case (i / 30)
				0: random_item(32'd1100, 40);
				1: random_item(32'd60, 60);
				2: random_item(32'hFFFF_FF80, 120);
				default: random_item(32'h8000_0000, 20);
			endcase
		end
		start <= 1'b0;

		fork
			begin
				while (pending_results.size() != 0)
					@(posedge clk);
				repeat (50) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
				mismatches++;
				$display("MISMATCH: results still pending at drain limit");
			end
		join_any
		disable fork;
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
